// ===== src/lmha_pkg.sv =====
// Shared types, constants and helper functions for the list-mode histogram accumulator.
`default_nettype none

package lmha_pkg;

  // Default geometry
  localparam int IMAGE_COLUMNS_DEF  = 400;
  localparam int IMAGE_ROWS_DEF     = 1024;
  localparam int TIME_BIN_WIDTH_DEF = 8;
  localparam int TIME_CHANNELS_DEF  = 8000;

  // Field widths
  localparam int X_W        = 10;
  localparam int Y_W        = 10;
  localparam int CHAN_W     = 3;
  localparam int TOF_W      = 24;
  localparam int RADDR_W    = 19;
  localparam int BIN_ADDR_W = 19;
  localparam int COUNT_W    = 32;

  // Internal address wide enough for the largest store the parameters allow (1024 x 1024)
  localparam int MEM_ADDR_W = 20;

  // Reciprocal scaling for the time binning
  localparam int RECIP_SHIFT = TOF_W;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [CHAN_W-1:0] STOP_CHANNEL_ID = 3'd1;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic MODE_IMAGING = 1'b0;
  localparam logic MODE_TOF     = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [X_W-1:0]      event_x;
    logic [Y_W-1:0]      event_y;
    logic [CHAN_W-1:0]   stop_channel;
    logic [TOF_W-1:0]    flight_time;
    logic [RADDR_W-1:0]  read_address;
  } lmha_in_t;

  typedef struct packed {
    logic                  accepted;
    logic [BIN_ADDR_W-1:0] bin_address;
    logic [COUNT_W-1:0]    bin_count;
  } lmha_out_t;

  typedef enum logic [1:0] {
    CMD_DROP,
    CMD_BUMP,
    CMD_READ
  } cmd_kind_t;

  // One classified item on its way from front to back
  typedef struct packed {
    cmd_kind_t             kind;
    logic [MEM_ADDR_W-1:0] mem_addr;
    logic [BIN_ADDR_W-1:0] out_addr;
  } lmha_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  function automatic int store_depth(int cols, int rows, int channels);
    int img_bins;
    img_bins = cols * rows;
    return (img_bins > channels) ? img_bins : channels;
  endfunction

  function automatic int addr_bits(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

// ===== src/lmha_front.sv =====
// Front end: accepts an item, computes and checks its bin address, queues the command.
`default_nettype none

module lmha_front
  import lmha_pkg::*;
#(
  parameter int IMAGE_COLUMNS  = IMAGE_COLUMNS_DEF,
  parameter int IMAGE_ROWS     = IMAGE_ROWS_DEF,
  parameter int TIME_BIN_WIDTH = TIME_BIN_WIDTH_DEF,
  parameter int TIME_CHANNELS  = TIME_CHANNELS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire lmha_in_t      item,
  input  wire logic          histogram_mode,
  input  wire back_status_t  back_stat,
  input  wire queue_status_t q_stat,
  output logic               busy,
  output logic               push,
  output lmha_cmd_t          cmd
);

  localparam int STORE_DEPTH = store_depth(IMAGE_COLUMNS, IMAGE_ROWS, TIME_CHANNELS);
  localparam int ROWS_W      = $clog2(IMAGE_ROWS + 1);
  localparam int IMG_W       = X_W + ROWS_W;
  localparam int RECIP_W     = TOF_W + 1;
  localparam int PROD_W      = TOF_W + RECIP_W;
  localparam int DIV_W       = $clog2(TIME_BIN_WIDTH + 1);
  localparam int TQ_W        = TOF_W + DIV_W;
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((1 << RECIP_SHIFT) / TIME_BIN_WIDTH);
  localparam logic [DIV_W-1:0]   DIVISOR = DIV_W'(TIME_BIN_WIDTH);

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_FIX,
    F_CHK,
    F_PUSH
  } front_state_t;

  front_state_t      st;
  lmha_in_t          itm;
  logic              md;
  logic [PROD_W-1:0] prod;
  logic [TOF_W-1:0]  q0;
  logic [TQ_W-1:0]   qd;
  lmha_cmd_t         cmd_next;

  logic [IMG_W-1:0]  img_prod;
  logic [PROD_W-1:0] tof_prod;
  logic [TOF_W-1:0]  q_est;
  logic [TQ_W-1:0]   rem;
  logic [TOF_W-1:0]  qbin;
  logic [31:0]       img_addr;
  logic [31:0]       bin32;
  logic [31:0]       rd32;
  logic              img_ok;
  logic              tof_ok;

  assign busy = (st != F_IDLE) || back_stat.clearing;
  assign push = (st == F_PUSH) && !q_stat.full;

  // Constant multiplies: x * rows, and time * reciprocal of the bin width
  assign img_prod = IMG_W'(itm.event_x) * IMG_W'(IMAGE_ROWS);
  assign tof_prod = PROD_W'(itm.flight_time) * PROD_W'(RECIP);
  assign q_est    = prod[RECIP_SHIFT+TOF_W-1:RECIP_SHIFT];

  always_comb begin
    // quotient estimate is low by at most one; fix with one compare
    rem      = TQ_W'(itm.flight_time) - qd;
    qbin     = q0 + TOF_W'(rem >= TQ_W'(DIVISOR));
    bin32    = 32'(qbin);
    img_addr = 32'(prod[IMG_W-1:0]) + 32'(itm.event_y);
    rd32     = 32'(itm.read_address);
    img_ok   = (32'(itm.event_x) < 32'(IMAGE_COLUMNS)) &&
               (32'(itm.event_y) < 32'(IMAGE_ROWS));
    tof_ok   = (itm.stop_channel == STOP_CHANNEL_ID) && (bin32 < 32'(TIME_CHANNELS));

    cmd_next = '{kind: CMD_DROP, mem_addr: '0, out_addr: '0};
    if (itm.opcode == OP_READ) begin
      cmd_next.out_addr = itm.read_address;
      if (rd32 < 32'(STORE_DEPTH)) begin
        cmd_next.kind     = CMD_READ;
        cmd_next.mem_addr = rd32[MEM_ADDR_W-1:0];
      end
    end else if (md == MODE_IMAGING) begin
      if (img_ok) begin
        cmd_next.kind     = CMD_BUMP;
        cmd_next.mem_addr = img_addr[MEM_ADDR_W-1:0];
        cmd_next.out_addr = img_addr[BIN_ADDR_W-1:0];
      end
    end else begin
      if (tof_ok) begin
        cmd_next.kind     = CMD_BUMP;
        cmd_next.mem_addr = bin32[MEM_ADDR_W-1:0];
        cmd_next.out_addr = bin32[BIN_ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
    end else begin
      case (st)
        F_IDLE: begin
          if (start && !back_stat.clearing) begin
            itm <= item;
            md  <= histogram_mode;
            st  <= F_MUL;
          end
        end
        F_MUL: begin
          prod <= (md == MODE_TOF) ? tof_prod : PROD_W'(img_prod);
          st   <= F_FIX;
        end
        F_FIX: begin
          q0 <= q_est;
          qd <= TQ_W'(q_est) * TQ_W'(DIVISOR);
          st <= F_CHK;
        end
        F_CHK: begin
          cmd <= cmd_next;
          st  <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_stat.full) begin
            st <= F_IDLE;
          end
        end
        default: begin
          st <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/lmha_queue.sv =====
// Short command queue between the front end and the histogram back end.
`default_nettype none

module lmha_queue
  import lmha_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire lmha_cmd_t push_cmd,
  input  wire logic      pop,
  output queue_status_t  q_stat,
  output lmha_cmd_t      head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  lmha_cmd_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign q_stat.full  = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/lmha_back.sv =====
// Back end: histogram memory, clearing pass, read-modify-write and result register.
`default_nettype none

module lmha_back
  import lmha_pkg::*;
#(
  parameter int STORE_DEPTH = store_depth(IMAGE_COLUMNS_DEF, IMAGE_ROWS_DEF,
                                          TIME_CHANNELS_DEF)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire queue_status_t q_stat,
  input  wire lmha_cmd_t     head,
  output logic               pop,
  output back_status_t       back_stat,
  output logic               done,
  output lmha_out_t          result
);

  localparam int ADDR_W = addr_bits(STORE_DEPTH);

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC
  } back_state_t;

  back_state_t         st;
  logic [ADDR_W-1:0]   clr_cnt;
  lmha_cmd_t           cmd;
  logic [COUNT_W-1:0]  mem [STORE_DEPTH];
  logic [COUNT_W-1:0]  rdata;
  logic [COUNT_W-1:0]  inc;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [COUNT_W-1:0]  mem_wdata;

  assign back_stat.clearing = (st == B_CLEAR);
  assign pop                = (st == B_IDLE) && !q_stat.empty;

  // saturating increment
  assign inc = (rdata == '1) ? rdata : rdata + 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cmd.mem_addr[ADDR_W-1:0];
    mem_wdata = inc;
    if (st == B_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (st == B_EXEC && cmd.kind == CMD_BUMP) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[head.mem_addr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= B_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        B_CLEAR: begin
          if (clr_cnt == ADDR_W'(STORE_DEPTH - 1)) begin
            st <= B_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        B_IDLE: begin
          if (!q_stat.empty) begin
            cmd <= head;
            st  <= B_EXEC;
          end
        end
        B_EXEC: begin
          done               <= 1'b1;
          result.bin_address <= cmd.out_addr;
          case (cmd.kind)
            CMD_BUMP: begin
              result.accepted  <= 1'b1;
              result.bin_count <= inc;
            end
            CMD_READ: begin
              result.accepted  <= 1'b1;
              result.bin_count <= rdata;
            end
            default: begin
              result.accepted  <= 1'b0;
              result.bin_count <= '0;
            end
          endcase
          st <= B_IDLE;
        end
        default: begin
          st <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/list_mode_histogram_accumulator_unit.sv =====
// Top level of the list-mode histogram accumulator: mode register, front end, queue, back end.
`default_nettype none

// Counts detector events into one store of 32-bit saturating bins and reads bins back.
// After reset the store of STORE_DEPTH bins (409600 with the default geometry) is
// cleared one bin per clock; busy stays high through that pass, while mode writes
// are still taken. An item is taken when start is high and busy is low, and busy
// then stays high while the front end runs its address arithmetic (a constant
// multiply, a reciprocal-divide correction, the range checks) and hands the command
// to the queue, waiting while the queue is full; only then is a new item taken. The
// back end pops a command in its idle state, with the memory's registered read,
// and writes back in its execute state. Each item gives exactly one result, shown
// on result for one cycle with done high. The receiver cannot hold results off.
// In imaging mode an event bumps bin x*IMAGE_ROWS+y; in time-of-flight mode an
// event on the stop channel bumps bin flight_time/TIME_BIN_WIDTH. Events outside the
// image, on another channel or past the last time channel give accepted = 0 with a
// zero address and count. A read returns any bin of the store in either mode.
// The mode is sampled when an item is taken; change it only while the block is idle.

module list_mode_histogram_accumulator_unit
  import lmha_pkg::*;
#(
  parameter int IMAGE_COLUMNS  = IMAGE_COLUMNS_DEF,
  parameter int IMAGE_ROWS     = IMAGE_ROWS_DEF,
  parameter int TIME_BIN_WIDTH = TIME_BIN_WIDTH_DEF,
  parameter int TIME_CHANNELS  = TIME_CHANNELS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire lmha_in_t item,
  output logic          busy,
  input  wire logic     mode_we,
  input  wire logic     mode_wdata,
  output logic          done,
  output lmha_out_t     result
);

  localparam int STORE_DEPTH = store_depth(IMAGE_COLUMNS, IMAGE_ROWS, TIME_CHANNELS);

  logic          histogram_mode;
  back_status_t  back_stat;
  queue_status_t q_stat;
  logic          push;
  logic          pop;
  lmha_cmd_t     push_cmd;
  lmha_cmd_t     head;

  // mode register: 0 = imaging, 1 = time-of-flight
  always_ff @(posedge clk) begin
    if (rst) begin
      histogram_mode <= MODE_IMAGING;
    end else if (mode_we) begin
      histogram_mode <= mode_wdata;
    end
  end

  lmha_front #(
    .IMAGE_COLUMNS  (IMAGE_COLUMNS),
    .IMAGE_ROWS     (IMAGE_ROWS),
    .TIME_BIN_WIDTH (TIME_BIN_WIDTH),
    .TIME_CHANNELS  (TIME_CHANNELS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .item           (item),
    .histogram_mode (histogram_mode),
    .back_stat      (back_stat),
    .q_stat         (q_stat),
    .busy           (busy),
    .push           (push),
    .cmd            (push_cmd)
  );

  // decouples classification from the memory side
  lmha_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_stat   (q_stat),
    .head     (head)
  );

  lmha_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .back_stat (back_stat),
    .done      (done),
    .result    (result)
  );

endmodule

`default_nettype wire
